// ===== hw/rtl/plagc_pkg.sv =====
// Package for the per-line automatic gain control block.
// Holds configuration types, register indexes and reset constants.
// No dependencies.
`default_nettype none

package plagc_pkg;

  localparam int LINES_DEF  = 128;
  localparam int FIFO_DEPTH = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_OVER_THRESHOLD      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_HALF_WIDTH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOWED_REVOLUTIONS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_STEP           = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_FLOOR          = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_INITIAL        = 3'd5;

  localparam logic [15:0] THRESHOLD_RST = 16'd60500;
  localparam logic [2:0]  ZONE_RST      = 3'd5;
  localparam logic [3:0]  ALLOWED_RST   = 4'd3;
  localparam logic [7:0]  STEP_RST      = 8'd10;
  localparam logic [7:0]  FLOOR_RST     = 8'd0;
  localparam logic [7:0]  GAIN_RST      = 8'd127;
  localparam logic [7:0]  COUNT_MAX     = 8'd255;

  // Line entry: mark, repeat count, gain
  localparam int ENTRY_W = 17;

  typedef struct packed {
    logic [15:0] over_threshold;
    logic [2:0]  zone_half_width;
    logic [3:0]  allowed_revolutions;
    logic [7:0]  gain_step;
    logic [7:0]  gain_floor;
    logic [7:0]  gain_initial;
  } cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/plagc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module plagc_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem_r [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/plagc_fifo.sv =====
// Small register queue with push/pop handshake.
// Depends on plagc_pkg for the depth.
`default_nettype none

module plagc_fifo
  import plagc_pkg::*;
#(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  output logic              full,
  input  wire logic         pop,
  output logic              empty,
  output logic      [W-1:0] rdata
);

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  logic [W-1:0]  mem_r [FIFO_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(FIFO_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= wp_r + PW'(1);
      end
      if (do_pop) begin
        rp_r <= rp_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/plagc_front.sv =====
// Front end: accepts samples, detects the first hit of a line and queues
// window-walk and end-of-line commands. Depends on plagc_pkg.
`default_nettype none

module plagc_front
  import plagc_pkg::*;
#(
  parameter int LINES = LINES_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     push,
  output logic                          full,
  input  wire logic [6:0]               in_line_number,
  input  wire logic [15:0]              in_sample_value,
  input  wire logic                     in_line_end,
  input  wire logic [15:0]              over_threshold,
  input  wire logic                     cmd_full,
  output logic                          cmd_push,
  output logic      [$clog2(LINES)-1:0] cmd_line,
  output logic                          cmd_walk,
  output logic                          cmd_end
);

  localparam int LW = $clog2(LINES);
  localparam int WW = ((LW > 7) ? LW : 7) + 3;

  logic          hit_r, hit_nxt;
  logic          accept, hit;
  logic [WW-1:0] v [4];

  assign full   = cmd_full;
  assign accept = push && !cmd_full;
  assign hit    = !hit_r && (in_sample_value > over_threshold);

  // reduce line number modulo LINES by binary compare-subtract
  always_comb begin
    v[0] = WW'(in_line_number);
    for (int s = 0; s < 3; s++) begin
      if (v[s] >= (WW'(LINES) << (2 - s))) begin
        v[s+1] = v[s] - (WW'(LINES) << (2 - s));
      end else begin
        v[s+1] = v[s];
      end
    end
  end

  assign cmd_line = v[3][LW-1:0];
  assign cmd_walk = hit;
  assign cmd_end  = in_line_end;
  assign cmd_push = accept && (hit || in_line_end);

  always_comb begin
    hit_nxt = hit_r;
    if (accept) begin
      if (in_line_end) begin
        hit_nxt = 1'b0;
      end else if (hit) begin
        hit_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= hit_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/plagc_back.sv =====
// Back end: clears the line table after reset, walks the attenuation window,
// cleans lines and emits gain changes. Depends on plagc_pkg.
`default_nettype none

module plagc_back
  import plagc_pkg::*;
#(
  parameter int LINES = LINES_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire cfg_t                     cfg,
  input  wire logic                     cmd_empty,
  output logic                          cmd_pop,
  input  wire logic [$clog2(LINES)-1:0] cmd_line,
  input  wire logic                     cmd_walk,
  input  wire logic                     cmd_end,
  output logic                          mem_we,
  output logic      [$clog2(LINES)-1:0] mem_waddr,
  output logic      [ENTRY_W-1:0]       mem_wdata,
  output logic      [$clog2(LINES)-1:0] mem_raddr,
  input  wire logic [ENTRY_W-1:0]       mem_rdata,
  input  wire logic                     out_full,
  output logic                          out_push,
  output logic      [6:0]               out_line,
  output logic      [7:0]               out_gain
);

  localparam int LW = $clog2(LINES);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_WRD, S_WWR, S_CRD, S_CWR, S_NRD, S_NCMP
  } state_t;

  state_t        state_r;
  logic [LW-1:0] init_r, t_r, clean_r, next_r;
  logic [3:0]    k_r;
  logic          end_r;
  logic [7:0]    last_r;

  logic [LW:0]   start_sum, clean_sum;
  logic [LW-1:0] start_a, clean_a, next_a, t_inc;
  logic [LW+6:0] next_ext;

  logic          e_mark;
  logic [7:0]    e_cnt, e_gain, cnt_new, gain_dec;
  logic [8:0]    gain_lim;
  logic          gain_diff;

  assign e_mark = mem_rdata[16];
  assign e_cnt  = mem_rdata[15:8];
  assign e_gain = mem_rdata[7:0];

  assign start_sum = (LW+1)'(cmd_line) + (LW+1)'(LINES) - (LW+1)'(cfg.zone_half_width);
  assign clean_sum = (LW+1)'(cmd_line) + (LW+1)'(LINES)
                   - (LW+1)'(cfg.zone_half_width) - (LW+1)'(1);
  assign start_a = (start_sum >= (LW+1)'(LINES)) ?
                   LW'(start_sum - (LW+1)'(LINES)) : LW'(start_sum);
  assign clean_a = (clean_sum >= (LW+1)'(LINES)) ?
                   LW'(clean_sum - (LW+1)'(LINES)) : LW'(clean_sum);
  assign next_a  = (cmd_line == LW'(LINES - 1)) ? '0 : cmd_line + LW'(1);
  assign t_inc   = (t_r == LW'(LINES - 1)) ? '0 : t_r + LW'(1);

  assign cnt_new  = (e_cnt < COUNT_MAX) ? e_cnt + 8'd1 : e_cnt;
  assign gain_lim = {1'b0, cfg.gain_floor} + {1'b0, cfg.gain_step};
  assign gain_dec = ({1'b0, e_gain} <= gain_lim) ? cfg.gain_floor : e_gain - cfg.gain_step;

  assign gain_diff = (e_gain != last_r);
  assign next_ext  = (LW+7)'(next_r);
  assign out_line  = next_ext[6:0];
  assign out_gain  = e_gain;
  assign out_push  = (state_r == S_NCMP) && gain_diff && !out_full;
  assign cmd_pop   = (state_r == S_IDLE) && !cmd_empty;

  always_comb begin
    case (state_r)
      S_CRD:          mem_raddr = clean_r;
      S_NRD, S_NCMP:  mem_raddr = next_r;
      default:        mem_raddr = t_r;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = t_r;
    mem_wdata = mem_rdata;
    case (state_r)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = init_r;
        mem_wdata = {1'b0, 8'd0, GAIN_RST};
      end
      S_WWR: begin
        mem_we    = !e_mark;
        mem_waddr = t_r;
        mem_wdata = {1'b1, cnt_new,
                     (cnt_new > {4'd0, cfg.allowed_revolutions}) ? gain_dec : e_gain};
      end
      S_CWR: begin
        mem_we    = 1'b1;
        mem_waddr = clean_r;
        mem_wdata = e_mark ? {1'b0, e_cnt, e_gain} : {1'b0, 8'd0, cfg.gain_initial};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      init_r  <= '0;
      last_r  <= GAIN_RST;
      t_r     <= '0;
      clean_r <= '0;
      next_r  <= '0;
      k_r     <= '0;
      end_r   <= 1'b0;
    end else begin
      case (state_r)
        S_INIT: begin
          init_r <= init_r + LW'(1);
          if (init_r == LW'(LINES - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!cmd_empty) begin
            t_r     <= start_a;
            clean_r <= clean_a;
            next_r  <= next_a;
            end_r   <= cmd_end;
            k_r     <= '0;
            state_r <= cmd_walk ? S_WRD : S_CRD;
          end
        end
        S_WRD: begin
          state_r <= S_WWR;
        end
        S_WWR: begin
          if (k_r == {cfg.zone_half_width, 1'b0}) begin
            state_r <= end_r ? S_CRD : S_IDLE;
          end else begin
            k_r     <= k_r + 4'd1;
            t_r     <= t_inc;
            state_r <= S_WRD;
          end
        end
        S_CRD: begin
          state_r <= S_CWR;
        end
        S_CWR: begin
          state_r <= S_NRD;
        end
        S_NRD: begin
          state_r <= S_NCMP;
        end
        S_NCMP: begin
          if (!gain_diff) begin
            state_r <= S_IDLE;
          end else if (!out_full) begin
            last_r  <= e_gain;
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/per_line_auto_gain_control.sv =====
// Top level of the per-line automatic gain control block.
// Depends on plagc_pkg, plagc_front, plagc_fifo, plagc_back and plagc_ram.
//
// Samples are taken one per cycle while the four-entry command queue has
// room; a sample that is neither the first hit of its line nor a line end
// adds no command. The back end works from a single-port-per-direction
// line table: a window walk reads each of the 2 * zone_half_width + 1 lines
// of the window and updates those not yet marked; an end of line cleans the
// line before the window and checks the gain of the line after the command's.
// After reset the table is cleared one entry per cycle while samples queue;
// then commands run. Gain changes wait in a four-entry result queue.
`default_nettype none

module per_line_auto_gain_control
  import plagc_pkg::*;
#(
  parameter int LINES = LINES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [6:0]            in_line_number,
  input  wire logic [15:0]           in_sample_value,
  input  wire logic                  in_line_end,
  output logic                       empty,
  input  wire logic                  pop,
  output logic      [6:0]            out_gain_line,
  output logic      [7:0]            out_gain_value,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int LW = $clog2(LINES);
  localparam int CMD_W = LW + 2;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.over_threshold      <= THRESHOLD_RST;
      cfg_r.zone_half_width     <= ZONE_RST;
      cfg_r.allowed_revolutions <= ALLOWED_RST;
      cfg_r.gain_step           <= STEP_RST;
      cfg_r.gain_floor          <= FLOOR_RST;
      cfg_r.gain_initial        <= GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OVER_THRESHOLD:      cfg_r.over_threshold      <= cfg_data;
        CFG_ZONE_HALF_WIDTH:     cfg_r.zone_half_width     <= cfg_data[2:0];
        CFG_ALLOWED_REVOLUTIONS: cfg_r.allowed_revolutions <= cfg_data[3:0];
        CFG_GAIN_STEP:           cfg_r.gain_step           <= cfg_data[7:0];
        CFG_GAIN_FLOOR:          cfg_r.gain_floor          <= cfg_data[7:0];
        CFG_GAIN_INITIAL:        cfg_r.gain_initial        <= cfg_data[7:0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  logic             f_push, f_walk, f_end, q_full, q_empty, q_pop;
  logic [LW-1:0]    f_line;
  logic [CMD_W-1:0] q_rdata;

  plagc_front #(.LINES(LINES)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_line_number  (in_line_number),
    .in_sample_value (in_sample_value),
    .in_line_end     (in_line_end),
    .over_threshold  (cfg_r.over_threshold),
    .cmd_full        (q_full),
    .cmd_push        (f_push),
    .cmd_line        (f_line),
    .cmd_walk        (f_walk),
    .cmd_end         (f_end)
  );

  plagc_fifo #(.W(CMD_W)) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .wdata ({f_walk, f_end, f_line}),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  logic               m_we;
  logic [LW-1:0]      m_waddr, m_raddr;
  logic [ENTRY_W-1:0] m_wdata, m_rdata;
  logic               o_push, o_full;
  logic [6:0]         o_line;
  logic [7:0]         o_gain;

  plagc_back #(.LINES(LINES)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_empty (q_empty),
    .cmd_pop   (q_pop),
    .cmd_line  (q_rdata[LW-1:0]),
    .cmd_walk  (q_rdata[LW+1]),
    .cmd_end   (q_rdata[LW]),
    .mem_we    (m_we),
    .mem_waddr (m_waddr),
    .mem_wdata (m_wdata),
    .mem_raddr (m_raddr),
    .mem_rdata (m_rdata),
    .out_full  (o_full),
    .out_push  (o_push),
    .out_line  (o_line),
    .out_gain  (o_gain)
  );

  plagc_ram #(.W(ENTRY_W), .D(LINES)) u_table (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .raddr (m_raddr),
    .rdata (m_rdata)
  );

  plagc_fifo #(.W(15)) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (o_push),
    .wdata ({o_line, o_gain}),
    .full  (o_full),
    .pop   (pop),
    .empty (empty),
    .rdata ({out_gain_line, out_gain_value})
  );

endmodule

`default_nettype wire
